// ----- rtl/core/m6502x_pkg.sv -----
// shared types and constants for the 6502 execute unit
// no dependencies
package m6502x_pkg;

    localparam logic [7:0] FL_N = 8'h80;
    localparam logic [7:0] FL_V = 8'h40;
    localparam logic [7:0] FL_U = 8'h20;
    localparam logic [7:0] FL_B = 8'h10;
    localparam logic [7:0] FL_D = 8'h08;
    localparam logic [7:0] FL_I = 8'h04;
    localparam logic [7:0] FL_Z = 8'h02;
    localparam logic [7:0] FL_C = 8'h01;

    localparam logic [7:0] SP_RESET = 8'hFD;
    localparam logic [7:0] P_RESET  = 8'h04;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] p;
        logic       jam;
    } regs_t;

    typedef struct packed {
        logic       we;
        logic [7:0] wd;
        logic       stk;
        logic       br;
    } bus_t;

endpackage

// ----- rtl/core/m6502x_alu.sv -----
// combinational next-state logic for one instruction
// depends on m6502x_pkg
module m6502x_alu
    import m6502x_pkg::*;
(
    input  logic [7:0] opcode,
    input  logic [7:0] operand,
    input  logic [7:0] address_high,
    input  logic       page_crossed,
    input  regs_t      cur,
    output regs_t      nxt,
    output bus_t       bus
);

    always_comb
    begin
        logic [2:0] aaa;
        logic [2:0] bbb;
        logic [1:0] cc;
        logic [7:0] d;
        logic [7:0] hi1;
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] p;
        logic       jam;
        logic       we;
        logic       stk;
        logic       br;
        logic [7:0] wd;
        logic [7:0] r;
        logic [7:0] t;
        logic [8:0] sum;
        logic [7:0] ax;
        logic [7:0] msk;
        logic       ci;

        aaa = opcode[7:5];
        bbb = opcode[4:2];
        cc  = opcode[1:0];
        d   = operand;
        hi1 = address_high + 8'd1;
        a = cur.a; x = cur.x; y = cur.y; s = cur.s; p = cur.p; jam = cur.jam;
        we = 1'b0; stk = 1'b0; br = 1'b0; wd = 8'h00; r = 8'h00; t = 8'h00;
        sum = 9'h000; ax = cur.a & cur.x; msk = 8'h00; ci = cur.p[0];

        if (!cur.jam)
        begin
            if (cc == 2'd1)
            begin
                if (opcode == 8'h89)
                begin
                end
                else if (aaa == 3'd4)
                begin
                    we = 1'b1; wd = a;
                end
                else
                begin
                    t = (aaa == 3'd7) ? ~d : d;
                    case (aaa)
                        3'd0: a = a | d;
                        3'd1: a = a & d;
                        3'd2: a = a ^ d;
                        3'd5: a = d;
                        3'd3, 3'd7:
                        begin
                            sum = {1'b0, a} + {1'b0, t} + {8'h00, ci};
                            p[6] = ~(a[7] ^ t[7]) & (a[7] ^ sum[7]);
                            p[0] = sum[8];
                            a = sum[7:0];
                        end
                        default: ;
                    endcase
                    if (aaa == 3'd6)
                    begin
                        r = a - d; p[0] = a >= d;
                        p[7] = r[7]; p[1] = (r == 8'h00);
                    end
                    else
                    begin
                        p[7] = a[7]; p[1] = (a == 8'h00);
                    end
                end
            end
            else if (cc == 2'd3)
            begin
                if (aaa < 3'd4)
                begin
                    if (bbb == 3'd2)
                    begin
                        a = a & d;
                        case (aaa)
                            3'd0, 3'd1: p[0] = a[7];
                            3'd2:
                            begin
                                p[0] = a[0]; a = {1'b0, a[7:1]};
                            end
                            default:
                            begin
                                a = {ci, a[7:1]};
                                p[0] = a[6]; p[6] = a[6] ^ a[5];
                            end
                        endcase
                        p[7] = a[7]; p[1] = (a == 8'h00);
                    end
                    else
                    begin
                        case (aaa)
                            3'd0: begin r = {d[6:0], 1'b0}; ci = d[7]; end
                            3'd1: begin r = {d[6:0], ci}; ci = d[7]; end
                            3'd2: begin r = {1'b0, d[7:1]}; ci = d[0]; end
                            default: begin r = {ci, d[7:1]}; ci = d[0]; end
                        endcase
                        p[0] = ci;
                        we = 1'b1; wd = r;
                        case (aaa)
                            3'd0: a = a | r;
                            3'd1: a = a & r;
                            3'd2: a = a ^ r;
                            default:
                            begin
                                sum = {1'b0, a} + {1'b0, r} + {8'h00, ci};
                                p[6] = ~(a[7] ^ r[7]) & (a[7] ^ sum[7]);
                                p[0] = sum[8];
                                a = sum[7:0];
                            end
                        endcase
                        p[7] = a[7]; p[1] = (a == 8'h00);
                    end
                end
                else if (aaa == 3'd4)
                begin
                    if (bbb == 3'd2)
                    begin
                        a = ax & d; p[7] = a[7]; p[1] = (a == 8'h00);
                    end
                    else if (bbb == 3'd6)
                    begin
                        s = ax; we = 1'b1; wd = ax & hi1;
                    end
                    else if (bbb == 3'd4 || bbb == 3'd7)
                    begin
                        we = 1'b1; wd = ax & hi1;
                    end
                    else
                    begin
                        we = 1'b1; wd = ax;
                    end
                end
                else if (aaa == 3'd5)
                begin
                    r = (bbb == 3'd6) ? (d & s) : d;
                    a = r; x = r;
                    if (bbb == 3'd6)
                        s = r;
                    p[7] = r[7]; p[1] = (r == 8'h00);
                end
                else if (aaa == 3'd6)
                begin
                    if (bbb == 3'd2)
                    begin
                        x = ax - d; p[7] = x[7]; p[1] = (x == 8'h00);
                        p[0] = ax >= d;
                    end
                    else
                    begin
                        r = d - 8'd1; we = 1'b1; wd = r;
                        t = a - r; p[0] = a >= r;
                        p[7] = t[7]; p[1] = (t == 8'h00);
                    end
                end
                else
                begin
                    r = (bbb == 3'd2) ? d : d + 8'd1;
                    if (bbb != 3'd2)
                    begin
                        we = 1'b1; wd = r;
                    end
                    t = ~r;
                    sum = {1'b0, a} + {1'b0, t} + {8'h00, ci};
                    p[6] = ~(a[7] ^ t[7]) & (a[7] ^ sum[7]);
                    p[0] = sum[8];
                    a = sum[7:0];
                    p[7] = a[7]; p[1] = (a == 8'h00);
                end
            end
            else if (cc == 2'd2)
            begin
                if (bbb == 3'd4)
                    jam = 1'b1;
                else if (aaa < 3'd4)
                begin
                    if (bbb == 3'd0)
                        jam = 1'b1;
                    else if (bbb == 3'd2 || bbb[0])
                    begin
                        t = (bbb == 3'd2) ? a : d;
                        case (aaa)
                            3'd0: begin r = {t[6:0], 1'b0}; p[0] = t[7]; end
                            3'd1: begin r = {t[6:0], ci}; p[0] = t[7]; end
                            3'd2: begin r = {1'b0, t[7:1]}; p[0] = t[0]; end
                            default: begin r = {ci, t[7:1]}; p[0] = t[0]; end
                        endcase
                        p[7] = r[7]; p[1] = (r == 8'h00);
                        if (bbb == 3'd2)
                            a = r;
                        else
                        begin
                            we = 1'b1; wd = r;
                        end
                    end
                end
                else if (aaa == 3'd4)
                begin
                    if (bbb == 3'd2)
                    begin
                        a = x; p[7] = a[7]; p[1] = (a == 8'h00);
                    end
                    else if (bbb == 3'd6)
                        s = x;
                    else if (bbb == 3'd7)
                    begin
                        if (!page_crossed)
                        begin
                            we = 1'b1; wd = x & hi1;
                        end
                    end
                    else if (bbb[0])
                    begin
                        we = 1'b1; wd = x;
                    end
                end
                else if (aaa == 3'd5)
                begin
                    if (bbb == 3'd2)
                        x = a;
                    else if (bbb == 3'd6)
                        x = s;
                    else
                        x = d;
                    p[7] = x[7]; p[1] = (x == 8'h00);
                end
                else if (bbb[0])
                begin
                    r = (aaa == 3'd6) ? d - 8'd1 : d + 8'd1;
                    we = 1'b1; wd = r; p[7] = r[7]; p[1] = (r == 8'h00);
                end
                else if (aaa == 3'd6 && bbb == 3'd2)
                begin
                    x = x - 8'd1; p[7] = x[7]; p[1] = (x == 8'h00);
                end
            end
            else
            begin
                if (opcode[4:0] == 5'h10)
                begin
                    case (opcode[7:6])
                        2'd0: msk = FL_N;
                        2'd1: msk = FL_V;
                        2'd2: msk = FL_C;
                        default: msk = FL_Z;
                    endcase
                    br = ((p & msk) != 8'h00) == opcode[5];
                end
                else
                begin
                    case (opcode)
                        8'h08:
                        begin
                            we = 1'b1; stk = 1'b1; wd = p | FL_B | FL_U; s = s - 8'd1;
                        end
                        8'h48:
                        begin
                            we = 1'b1; stk = 1'b1; wd = a; s = s - 8'd1;
                        end
                        8'h28:
                        begin
                            s = s + 8'd1; p = (d & ~FL_B) | FL_U;
                        end
                        8'h68:
                        begin
                            s = s + 8'd1; a = d; p[7] = d[7]; p[1] = (d == 8'h00);
                        end
                        8'h18: p[0] = 1'b0;
                        8'h38: p[0] = 1'b1;
                        8'h58: p[2] = 1'b0;
                        8'h78: p[2] = 1'b1;
                        8'hB8: p[6] = 1'b0;
                        8'hD8: p[3] = 1'b0;
                        8'hF8: p[3] = 1'b1;
                        8'h24, 8'h2C:
                        begin
                            p[7] = d[7]; p[6] = d[6]; p[1] = ((a & d) == 8'h00);
                        end
                        8'h84, 8'h8C, 8'h94:
                        begin
                            we = 1'b1; wd = y;
                        end
                        8'h9C:
                        begin
                            if (!page_crossed)
                            begin
                                we = 1'b1; wd = y & hi1;
                            end
                        end
                        8'h88: begin y = y - 8'd1; p[7] = y[7]; p[1] = (y == 8'h00); end
                        8'hC8: begin y = y + 8'd1; p[7] = y[7]; p[1] = (y == 8'h00); end
                        8'hE8: begin x = x + 8'd1; p[7] = x[7]; p[1] = (x == 8'h00); end
                        8'h98: begin a = y; p[7] = a[7]; p[1] = (a == 8'h00); end
                        8'hA8: begin y = a; p[7] = y[7]; p[1] = (y == 8'h00); end
                        8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC:
                        begin
                            y = d; p[7] = d[7]; p[1] = (d == 8'h00);
                        end
                        8'hC0, 8'hC4, 8'hCC, 8'hE0, 8'hE4, 8'hEC:
                        begin
                            t = opcode[5] ? x : y;
                            r = t - d; p[0] = t >= d;
                            p[7] = r[7]; p[1] = (r == 8'h00);
                        end
                        default: ;
                    endcase
                end
            end
        end

        nxt.a = a; nxt.x = x; nxt.y = y; nxt.s = s; nxt.p = p; nxt.jam = jam;
        bus.we  = we;
        bus.wd  = we ? wd : 8'h00;
        bus.stk = we & stk;
        bus.br  = br;
    end

endmodule

// ----- rtl/core/mos6502_execute_unit.sv -----
// execute stage of an nmos 6502, legal and illegal opcodes
// Use: one item (opcode, operand byte, address high byte, page crossing)
// enters on the input valid/ready channel; one result item leaves on the
// output channel with the store request, branch decision, jam flag and
// the architectural registers after the instruction.
// Output valid is registered at the acceptance edge. Throughput: one item
// per cycle while results are taken; the register file and the result register
// are updated at the acceptance edge, and the next item may then enter.
// The rate is set by the single pass through the decode and alu logic.
// Input ready is high whenever the result register is empty or is being
// taken in the same cycle, so a stalled receiver holds the result and
// stops intake.
// Reset: A, X, Y cleared, S = 0xFD, P = 0x04, jam flag cleared, no result
// pending. Once a jam opcode is seen every later item changes nothing.
// depends on m6502x_pkg and m6502x_alu
module mos6502_execute_unit
    import m6502x_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] opcode,
    input  logic [7:0] operand,
    input  logic [7:0] address_high,
    input  logic       page_crossed,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       write_enable,
    output logic [7:0] write_data,
    output logic       to_stack,
    output logic       branch_taken,
    output logic       jammed,
    output logic [7:0] acc_value,
    output logic [7:0] x_value,
    output logic [7:0] y_value,
    output logic [7:0] sp_value,
    output logic [7:0] status_value
);

    regs_t regs_reg;
    regs_t regs_next;
    bus_t  bus_reg;
    bus_t  bus_next;
    logic  valid_reg;
    logic  accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    m6502x_alu u_alu (
        .opcode       (opcode),
        .operand      (operand),
        .address_high (address_high),
        .page_crossed (page_crossed),
        .cur          (regs_reg),
        .nxt          (regs_next),
        .bus          (bus_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg  <= '{a: 8'h00, x: 8'h00, y: 8'h00, s: SP_RESET, p: P_RESET, jam: 1'b0};
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                regs_reg <= regs_next;
            if (accept)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            bus_reg <= bus_next;
    end

    assign out_valid    = valid_reg;
    assign write_enable = bus_reg.we;
    assign write_data   = bus_reg.wd;
    assign to_stack     = bus_reg.stk;
    assign branch_taken = bus_reg.br;
    assign jammed       = regs_reg.jam;
    assign acc_value    = regs_reg.a;
    assign x_value      = regs_reg.x;
    assign y_value      = regs_reg.y;
    assign sp_value     = regs_reg.s;
    assign status_value = regs_reg.p;

`ifndef SYNTHESIS
    // a jammed core never leaves the jam state
    a_jam_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        regs_reg.jam |=> regs_reg.jam)
        else $error("jam flag cleared");
    // A and S hold across an accepted item while jammed
    a_jam_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (regs_reg.jam && accept) |=> $stable(regs_reg.a) && $stable(regs_reg.s))
        else $error("register changed while jammed");
    // stack mark only with a store
    a_stk_we: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && to_stack |-> write_enable)
        else $error("stack mark without store");
    // no intake while a result is stalled
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |-> !in_ready)
        else $error("intake during stall");
`endif

endmodule

// ----- dv/mos6502_execute_unit_checker.sv -----
// checker for the 6502 execute unit: watches both channels, predicts each result
// from its own register copy and compares field by field
// depends on m6502x_pkg for the flag masks and reset values
`timescale 1ns / 1ps

module mos6502_execute_unit_checker
    import m6502x_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] opcode,
    input  logic [7:0] operand,
    input  logic [7:0] address_high,
    input  logic       page_crossed,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       write_enable,
    input  logic [7:0] write_data,
    input  logic       to_stack,
    input  logic       branch_taken,
    input  logic       jammed,
    input  logic [7:0] acc_value,
    input  logic [7:0] x_value,
    input  logic [7:0] y_value,
    input  logic [7:0] sp_value,
    input  logic [7:0] status_value,
    output int         fail_count,
    output int         pending
);

    localparam logic [7:0] OP_PHP = 8'h08;
    localparam logic [7:0] OP_PHA = 8'h48;
    localparam logic [7:0] OP_PLP = 8'h28;
    localparam logic [7:0] OP_PLA = 8'h68;
    localparam logic [7:0] OP_CLC = 8'h18;
    localparam logic [7:0] OP_SEC = 8'h38;
    localparam logic [7:0] OP_CLI = 8'h58;
    localparam logic [7:0] OP_SEI = 8'h78;
    localparam logic [7:0] OP_CLV = 8'hB8;
    localparam logic [7:0] OP_CLD = 8'hD8;
    localparam logic [7:0] OP_SED = 8'hF8;
    localparam logic [7:0] OP_BIT_ZP = 8'h24;
    localparam logic [7:0] OP_BIT_ABS = 8'h2C;
    localparam logic [7:0] OP_STY_ZP = 8'h84;
    localparam logic [7:0] OP_STY_ABS = 8'h8C;
    localparam logic [7:0] OP_STY_ZPX = 8'h94;
    localparam logic [7:0] OP_SHY = 8'h9C;
    localparam logic [7:0] OP_DEY = 8'h88;
    localparam logic [7:0] OP_INY = 8'hC8;
    localparam logic [7:0] OP_INX = 8'hE8;
    localparam logic [7:0] OP_TYA = 8'h98;
    localparam logic [7:0] OP_TAY = 8'hA8;
    localparam logic [7:0] OP_LDY_IMM = 8'hA0;
    localparam logic [7:0] OP_LDY_ZP = 8'hA4;
    localparam logic [7:0] OP_LDY_ABS = 8'hAC;
    localparam logic [7:0] OP_LDY_ZPX = 8'hB4;
    localparam logic [7:0] OP_LDY_ABX = 8'hBC;
    localparam logic [7:0] OP_CPY_IMM = 8'hC0;
    localparam logic [7:0] OP_CPY_ZP = 8'hC4;
    localparam logic [7:0] OP_CPY_ABS = 8'hCC;
    localparam logic [7:0] OP_CPX_IMM = 8'hE0;
    localparam logic [7:0] OP_CPX_ZP = 8'hE4;
    localparam logic [7:0] OP_CPX_ABS = 8'hEC;
    localparam logic [7:0] OP_BIT_IMM_NOP = 8'h89;
    localparam logic [7:0] BRANCH_MASK = 8'h1F;
    localparam logic [7:0] BRANCH_BITS = 8'h10;

    localparam logic [2:0] ALU_ORA = 3'd0;
    localparam logic [2:0] ALU_AND = 3'd1;
    localparam logic [2:0] ALU_EOR = 3'd2;
    localparam logic [2:0] ALU_ADC = 3'd3;
    localparam logic [2:0] ALU_LDA = 3'd5;
    localparam logic [2:0] ALU_CMP = 3'd6;
    localparam logic [2:0] ALU_SBC = 3'd7;

    localparam logic [1:0] SH_ASL = 2'd0;
    localparam logic [1:0] SH_ROL = 2'd1;
    localparam logic [1:0] SH_LSR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    typedef struct packed {
        logic       we;
        logic [7:0] wd;
        logic       stk;
        logic       br;
        logic       jam;
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] p;
    } cpu_result_t;

    logic [7:0] reg_a, reg_x, reg_y, reg_s, reg_p;
    logic       is_jammed;
    cpu_result_t result_queue[$];

    function automatic void put_flag(logic [7:0] mask, logic on);
        reg_p = on ? (reg_p | mask) : (reg_p & ~mask);
    endfunction

    function automatic void put_nz(logic [7:0] v);
        put_flag(FL_N, v[7]);
        put_flag(FL_Z, v == 8'h00);
    endfunction

    function automatic void add_carry(logic [7:0] d);
        logic [8:0] sum;
        logic [7:0] r;
        sum = {1'b0, reg_a} + {1'b0, d} + {8'h00, reg_p[0]};
        r = sum[7:0];
        put_flag(FL_C, sum[8]);
        put_flag(FL_V, (~(reg_a ^ d) & (reg_a ^ r) & 8'h80) != 8'h00);
        reg_a = r;
        put_nz(reg_a);
    endfunction

    function automatic void compare_reg(logic [7:0] rg, logic [7:0] d);
        put_flag(FL_C, rg >= d);
        put_nz(rg - d);
    endfunction

    function automatic logic [7:0] shift_byte(logic [1:0] kind, logic [7:0] v);
        logic       cin;
        logic [7:0] r;
        cin = reg_p[0];
        if (kind == SH_ASL || kind == SH_ROL)
        begin
            r = {v[6:0], (kind == SH_ROL) ? cin : 1'b0};
            put_flag(FL_C, v[7]);
        end
        else
        begin
            r = {(kind == SH_ROR) ? cin : 1'b0, v[7:1]};
            put_flag(FL_C, v[0]);
        end
        put_nz(r);
        return r;
    endfunction

    function automatic void alu(logic [2:0] aaa, logic [7:0] d);
        case (aaa)
            ALU_ORA: begin reg_a = reg_a | d; put_nz(reg_a); end
            ALU_AND: begin reg_a = reg_a & d; put_nz(reg_a); end
            ALU_EOR: begin reg_a = reg_a ^ d; put_nz(reg_a); end
            ALU_ADC: add_carry(d);
            ALU_LDA: begin reg_a = d; put_nz(reg_a); end
            ALU_CMP: compare_reg(reg_a, d);
            ALU_SBC: add_carry(~d);
            default: ;
        endcase
    endfunction

    function automatic cpu_result_t execute(logic [7:0] op, logic [7:0] d,
                                            logic [7:0] ahi, logic crossed);
        cpu_result_t e;
        logic [7:0] hi1, r;
        logic [2:0] aaa, bbb;
        logic [1:0] cc;
        logic       we, stk, br, cond;
        logic [7:0] wd;
        hi1 = ahi + 8'd1;
        aaa = op[7:5];
        bbb = op[4:2];
        cc = op[1:0];
        we = 0; stk = 0; br = 0; wd = 8'h00;
        if (!is_jammed)
        begin
            if (cc == 2'd1)
            begin
                if (op == OP_BIT_IMM_NOP) ;
                else if (aaa == 3'd4) begin we = 1; wd = reg_a; end
                else alu(aaa, d);
            end
            else if (cc == 2'd3)
            begin
                if (aaa < 3'd4)
                begin
                    if (bbb == 3'd2)
                    begin
                        // anc / alr / arr family
                        reg_a = reg_a & d;
                        put_nz(reg_a);
                        if (aaa < 3'd2)
                            put_flag(FL_C, reg_a[7]);
                        else if (aaa == 3'd2)
                            reg_a = shift_byte(SH_LSR, reg_a);
                        else
                        begin
                            reg_a = {reg_p[0], reg_a[7:1]};
                            put_nz(reg_a);
                            put_flag(FL_C, reg_a[6]);
                            put_flag(FL_V, reg_a[6] ^ reg_a[5]);
                        end
                    end
                    else
                    begin
                        r = shift_byte(aaa[1:0], d);
                        we = 1; wd = r;
                        case (aaa[1:0])
                            2'd0: begin reg_a = reg_a | r; put_nz(reg_a); end
                            2'd1: begin reg_a = reg_a & r; put_nz(reg_a); end
                            2'd2: begin reg_a = reg_a ^ r; put_nz(reg_a); end
                            default: add_carry(r);
                        endcase
                    end
                end
                else if (aaa == 3'd4)
                begin
                    if (bbb == 3'd2)
                    begin
                        reg_a = reg_a & reg_x & d;
                        put_nz(reg_a);
                    end
                    else if (bbb == 3'd6)
                    begin
                        reg_s = reg_a & reg_x;
                        we = 1; wd = reg_s & hi1;
                    end
                    else if (bbb == 3'd4 || bbb == 3'd7)
                    begin
                        we = 1; wd = reg_a & reg_x & hi1;
                    end
                    else
                    begin
                        we = 1; wd = reg_a & reg_x;
                    end
                end
                else if (aaa == 3'd5)
                begin
                    r = (bbb == 3'd6) ? (d & reg_s) : d;
                    reg_a = r; reg_x = r;
                    if (bbb == 3'd6) reg_s = r;
                    put_nz(r);
                end
                else if (aaa == 3'd6)
                begin
                    if (bbb == 3'd2)
                    begin
                        r = reg_a & reg_x;
                        reg_x = r - d;
                        put_nz(reg_x);
                        put_flag(FL_C, r >= d);
                    end
                    else
                    begin
                        r = d - 8'd1;
                        we = 1; wd = r;
                        compare_reg(reg_a, r);
                    end
                end
                else
                begin
                    if (bbb == 3'd2) alu(ALU_SBC, d);
                    else
                    begin
                        r = d + 8'd1;
                        we = 1; wd = r;
                        alu(ALU_SBC, r);
                    end
                end
            end
            else if (cc == 2'd2)
            begin
                if (bbb == 3'd4) is_jammed = 1;
                else if (aaa < 3'd4)
                begin
                    if (bbb == 3'd2) reg_a = shift_byte(aaa[1:0], reg_a);
                    else if (bbb[0]) begin we = 1; wd = shift_byte(aaa[1:0], d); end
                    else if (bbb == 3'd0) is_jammed = 1;
                end
                else if (aaa == 3'd4)
                begin
                    if (bbb == 3'd2) begin reg_a = reg_x; put_nz(reg_a); end
                    else if (bbb == 3'd6) reg_s = reg_x;
                    else if (bbb == 3'd7)
                    begin
                        if (!crossed) begin we = 1; wd = reg_x & hi1; end
                    end
                    else if (bbb[0]) begin we = 1; wd = reg_x; end
                end
                else if (aaa == 3'd5)
                begin
                    if (bbb == 3'd2) reg_x = reg_a;
                    else if (bbb == 3'd6) reg_x = reg_s;
                    else reg_x = d;
                    put_nz(reg_x);
                end
                else if (bbb[0])
                begin
                    r = (aaa == 3'd6) ? d - 8'd1 : d + 8'd1;
                    we = 1; wd = r; put_nz(r);
                end
                else if (aaa == 3'd6 && bbb == 3'd2)
                begin
                    reg_x = reg_x - 8'd1; put_nz(reg_x);
                end
            end
            else if ((op & BRANCH_MASK) == BRANCH_BITS)
            begin
                case (op[7:6])
                    2'd0: cond = reg_p[7];
                    2'd1: cond = reg_p[6];
                    2'd2: cond = reg_p[0];
                    default: cond = reg_p[1];
                endcase
                br = (cond == op[5]);
            end
            else
            begin
                case (op)
                    OP_PHP: begin we = 1; stk = 1; wd = reg_p | FL_B | FL_U;
                                  reg_s = reg_s - 8'd1; end
                    OP_PHA: begin we = 1; stk = 1; wd = reg_a; reg_s = reg_s - 8'd1; end
                    OP_PLP: begin reg_s = reg_s + 8'd1; reg_p = (d & ~FL_B) | FL_U; end
                    OP_PLA: begin reg_s = reg_s + 8'd1; reg_a = d; put_nz(d); end
                    OP_CLC: put_flag(FL_C, 0);
                    OP_SEC: put_flag(FL_C, 1);
                    OP_CLI: put_flag(FL_I, 0);
                    OP_SEI: put_flag(FL_I, 1);
                    OP_CLV: put_flag(FL_V, 0);
                    OP_CLD: put_flag(FL_D, 0);
                    OP_SED: put_flag(FL_D, 1);
                    OP_BIT_ZP, OP_BIT_ABS:
                    begin
                        put_flag(FL_N, d[7]);
                        put_flag(FL_V, d[6]);
                        put_flag(FL_Z, (reg_a & d) == 8'h00);
                    end
                    OP_STY_ZP, OP_STY_ABS, OP_STY_ZPX: begin we = 1; wd = reg_y; end
                    OP_SHY: if (!crossed) begin we = 1; wd = reg_y & hi1; end
                    OP_DEY: begin reg_y = reg_y - 8'd1; put_nz(reg_y); end
                    OP_INY: begin reg_y = reg_y + 8'd1; put_nz(reg_y); end
                    OP_INX: begin reg_x = reg_x + 8'd1; put_nz(reg_x); end
                    OP_TYA: begin reg_a = reg_y; put_nz(reg_a); end
                    OP_TAY: begin reg_y = reg_a; put_nz(reg_y); end
                    OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ABS, OP_LDY_ZPX, OP_LDY_ABX:
                    begin
                        reg_y = d; put_nz(d);
                    end
                    OP_CPY_IMM, OP_CPY_ZP, OP_CPY_ABS: compare_reg(reg_y, d);
                    OP_CPX_IMM, OP_CPX_ZP, OP_CPX_ABS: compare_reg(reg_x, d);
                    default: ;
                endcase
            end
        end
        e.we = we;
        e.wd = we ? wd : 8'h00;
        e.stk = we && stk;
        e.br = br;
        e.jam = is_jammed;
        e.a = reg_a; e.x = reg_x; e.y = reg_y; e.s = reg_s; e.p = reg_p;
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cpu_result_t want, got;
        if (!rst_n)
        begin
            reg_a = 8'h00; reg_x = 8'h00; reg_y = 8'h00;
            reg_s = SP_RESET; reg_p = P_RESET; is_jammed = 0;
            result_queue.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{write_enable, write_data, to_stack, branch_taken, jammed,
                        acc_value, x_value, y_value, sp_value, status_value};
                if (result_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item: %h", got);
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch we/wd/stk/br/jam exp %b %h %b %b %b got ",
                                      "%b %h %b %b %b; a x y s p exp %h %h %h %h %h ",
                                      "got %h %h %h %h %h"},
                                     want.we, want.wd, want.stk, want.br, want.jam,
                                     got.we, got.wd, got.stk, got.br, got.jam,
                                     want.a, want.x, want.y, want.s, want.p,
                                     got.a, got.x, got.y, got.s, got.p);
                    end
                end
            end
            if (in_valid && in_ready)
                result_queue.push_back(execute(opcode, operand, address_high, page_crossed));
            pending = result_queue.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
// top of the 6502 execute unit testbench: clock, reset, stimulus, back-pressure,
// watchdog and verdict; depends on mos6502_execute_unit and its checker
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_OFF_CYCLES = 300;

    localparam logic [7:0] OP_LDA_IMM = 8'hA9;
    localparam logic [7:0] OP_LDX_IMM = 8'hA2;
    localparam logic [7:0] OP_ADC_IMM = 8'h69;
    localparam logic [7:0] OP_SBC_IMM = 8'hE9;
    localparam logic [7:0] OP_CMP_IMM = 8'hC9;
    localparam logic [7:0] OP_PUSH_A = 8'h48;
    localparam logic [7:0] OP_PUSH_P = 8'h08;
    localparam logic [7:0] OP_PULL_P = 8'h28;
    localparam logic [7:0] OP_PULL_A = 8'h68;
    localparam logic [7:0] OP_ANE = 8'h8B;
    localparam logic [7:0] OP_LXA = 8'hAB;
    localparam logic [7:0] OP_LAS = 8'hBB;
    localparam logic [7:0] OP_SBX = 8'hCB;
    localparam logic [7:0] OP_SHA = 8'h9F;
    localparam logic [7:0] OP_SHX = 8'h9E;
    localparam logic [7:0] OP_SHY_ABX = 8'h9C;
    localparam logic [7:0] OP_TAS = 8'h9B;
    localparam logic [7:0] OP_BIT = 8'h2C;
    localparam logic [7:0] OP_BPL = 8'h10;
    localparam logic [7:0] OP_BEQ = 8'hF0;
    localparam logic [7:0] OP_BRK = 8'h00;
    localparam logic [7:0] OP_JSR = 8'h20;
    localparam logic [7:0] OP_NOP_IMPL = 8'h1A;
    localparam logic [7:0] OP_DCP = 8'hC7;
    localparam logic [7:0] OP_ISC = 8'hE7;
    localparam logic [7:0] OP_ARR = 8'h6B;
    localparam logic [7:0] OP_SET_C = 8'h38;
    localparam logic [7:0] OP_JAM = 8'h02;
    localparam logic [7:0] JAM_COL_MASK = 8'h1F;
    localparam logic [7:0] JAM_COL_BITS = 8'h12;
    localparam logic [7:0] JAM_ROW_MASK = 8'h9F;
    localparam logic [7:0] JAM_ROW_BITS = 8'h02;

    logic       clk, rst_n;
    logic       in_valid, in_ready, out_valid, out_ready;
    logic [7:0] opcode, operand, address_high;
    logic       page_crossed;
    logic       write_enable, to_stack, branch_taken, jammed;
    logic [7:0] write_data, acc_value, x_value, y_value, sp_value, status_value;
    int         fail_count, pending;
    logic       hold_request;
    int         idle_cycles;

    mos6502_execute_unit uut (.*);
    mos6502_execute_unit_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic logic halts_core(logic [7:0] op);
        return (op & JAM_COL_MASK) == JAM_COL_BITS || (op & JAM_ROW_MASK) == JAM_ROW_BITS;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 19) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one item at the falling edge and hold it until taken
    task automatic offer(logic [7:0] op, logic [7:0] d, logic [7:0] ahi, logic crossed,
                         int gap);
        if (gap > 0)
        begin
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1;
        opcode = op; operand = d; address_high = ahi; page_crossed = crossed;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic offer_random(logic allow_jam, int gap);
        logic [7:0] op;
        op = 8'($urandom_range(0, 255));
        while (!allow_jam && halts_core(op)) op = 8'($urandom_range(0, 255));
        offer(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), gap);
    endtask

    // receiver: random stalls in some stretches, none in others, one long hold-off
    initial
    begin
        int mode;
        logic hold_done;
        out_ready = 0;
        mode = 0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                out_ready = 0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_done = 1;
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 1);
            if (mode == 0)
                out_ready = 1;
            else
            begin
                out_ready = 1;
                if ($urandom_range(0, 3) == 0)
                begin
                    out_ready = 0;
                    repeat (pick_gap()) @(negedge clk);
                end
            end
        end
    end

    // watchdog: cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("[mos6502_execute_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        int busy;
        rst_n = 0;
        in_valid = 0;
        opcode = 8'h00; operand = 8'h00; address_high = 8'h00; page_crossed = 0;
        hold_request = 0;
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: reset state, extremes, stack, unstable illegals, stores
        offer(OP_BRK, 8'h00, 8'h00, 0, 0);
        offer(OP_LDA_IMM, 8'h00, 8'hFF, 1, 0);
        offer(OP_LDA_IMM, 8'hFF, 8'h00, 0, 0);
        offer(OP_LDX_IMM, 8'h80, 8'hFF, 0, 0);
        offer(OP_ADC_IMM, 8'h7F, 8'h00, 0, 0);
        offer(OP_SBC_IMM, 8'h80, 8'h00, 0, 0);
        offer(OP_CMP_IMM, 8'hFF, 8'h00, 0, 0);
        offer(OP_PUSH_A, 8'h00, 8'h00, 0, 0);
        offer(OP_PUSH_P, 8'h00, 8'h00, 0, 0);
        offer(OP_PULL_P, 8'hFF, 8'h00, 0, 0);
        offer(OP_PULL_A, 8'h00, 8'h00, 0, 0);
        offer(OP_LDA_IMM, 8'hF0, 8'h00, 0, 0);
        offer(OP_ANE, 8'h3C, 8'h00, 0, 0);
        offer(OP_LXA, 8'hC3, 8'h00, 0, 0);
        offer(OP_LAS, 8'h00, 8'h00, 0, 0);
        offer(OP_LDA_IMM, 8'hFF, 8'h00, 0, 0);
        offer(OP_SBX, 8'h01, 8'h00, 0, 0);
        offer(OP_SHA, 8'h55, 8'hFF, 0, 0);
        offer(OP_SHX, 8'h00, 8'h7E, 1, 0);
        offer(OP_SHX, 8'h00, 8'h7E, 0, 0);
        offer(OP_SHY_ABX, 8'h00, 8'h10, 0, 0);
        offer(OP_TAS, 8'h00, 8'h3F, 0, 0);
        offer(OP_BIT, 8'hC0, 8'h00, 0, 0);
        offer(OP_BPL, 8'h00, 8'h00, 0, 0);
        offer(OP_BEQ, 8'h00, 8'h00, 0, 0);
        offer(OP_JSR, 8'h12, 8'h34, 0, 0);
        offer(OP_NOP_IMPL, 8'hAA, 8'h00, 0, 0);
        offer(OP_DCP, 8'h00, 8'h00, 0, 0);
        offer(OP_ISC, 8'hFF, 8'h00, 0, 0);
        offer(OP_SET_C, 8'h00, 8'h00, 0, 0);
        offer(OP_ARR, 8'hFF, 8'h00, 0, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3) hold_request = 1;
            offer_random(0, pick_gap());
        end

        // halt the core, then check that nothing more changes
        offer(OP_JAM, 8'h5A, 8'hA5, 1, 0);
        for (int i = 0; i < 24; i++) offer_random(1, pick_gap());
        in_valid = 0;

        busy = 0;
        while (pending != 0 && busy < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            busy++;
        end
        repeat (5) @(posedge clk);
        if (pending == 0 && fail_count == 0)
            $display("[mos6502_execute_unit] OK");
        else
            $display("[mos6502_execute_unit] ERROR");
        $finish;
    end

endmodule
